### design/nsm3_pkg.sv
// nsm3_pkg: item types and binary32 multiply/add helper functions
// for the nan-safe 3x3 matrix multiply; no dependencies
package nsm3_pkg;

    localparam int unsigned Dim = 3;
    localparam int unsigned RowsKept = 2;
    localparam int unsigned Lanes = Dim * Dim;
    localparam logic [31:0] QnanBits = 32'h7FC0_0000;
    localparam logic [1:0] LastRow = 2'd2;

    typedef struct packed {
        logic [1:0]  row_index;
        logic [31:0] left_col0;
        logic [31:0] left_col1;
        logic [31:0] left_col2;
        logic [31:0] right_col0;
        logic [31:0] right_col1;
        logic [31:0] right_col2;
    } nsm3_in_t;

    typedef struct packed {
        logic [31:0] out_r0c0;
        logic [31:0] out_r0c1;
        logic [31:0] out_r0c2;
        logic [31:0] out_r1c0;
        logic [31:0] out_r1c1;
        logic [31:0] out_r1c2;
        logic [31:0] out_r2c0;
        logic [31:0] out_r2c1;
        logic [31:0] out_r2c2;
    } nsm3_out_t;

    typedef struct packed {
        logic [2:0][31:0] left;
        logic [2:0][31:0] right;
    } lane_ops_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } lane_stat_t;

    typedef enum logic [1:0] {
        K_NUM,
        K_ZERO,
        K_INF,
        K_NAN
    } fp_kind_t;

    typedef struct packed {
        fp_kind_t    kind;
        logic        sign;
        logic [47:0] prod;
        logic [8:0]  esum;
    } mul_mid_t;

    typedef struct packed {
        fp_kind_t    kind;
        logic        sign;
        logic        zero_sign;
        logic [27:0] sum;
        logic [7:0]  exp;
    } add_mid_t;

    typedef struct packed {
        logic        nan;
        logic [31:0] bits;
    } fp_res_t;

    function automatic logic is_nan(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // sig: 24 significand bits, round bit, sticky bit; leading one at top
    function automatic logic [31:0] round_pack(logic sgn, logic signed [10:0] exp,
                                               logic [25:0] sig);
        logic [10:0]        sh;
        logic [25:0]        s2;
        logic               lost;
        logic               inc;
        logic [24:0]        m25;
        logic signed [10:0] e2;
        logic signed [10:0] ebig;
        logic [31:0]        r;
        sh = 11'd0;
        s2 = sig;
        e2 = exp;
        if (exp < 11'sd1)
        begin
            sh = 11'sd1 - exp;
            e2 = 11'sd0;
            if (sh > 11'd26)
            begin
                s2 = {25'd0, |sig};
            end
            else
            begin
                s2 = sig >> sh[4:0];
                lost = |(sig & ~({26{1'b1}} << sh[4:0]));
                s2[0] = s2[0] | lost;
            end
        end
        inc = s2[1] & (s2[0] | s2[2]);
        m25 = {1'b0, s2[25:2]} + {24'd0, inc};
        ebig = e2 + $signed({10'd0, m25[24]});
        if (e2 == 11'sd0)
            r = {sgn, 7'd0, m25[23], m25[22:0]};
        else if (ebig >= 11'sd255)
            r = {sgn, 8'hFF, 23'd0};
        else if (m25[24])
            r = {sgn, ebig[7:0], m25[23:1]};
        else
            r = {sgn, ebig[7:0], m25[22:0]};
        return r;
    endfunction

    function automatic mul_mid_t mul_front(logic [31:0] a, logic [31:0] b);
        mul_mid_t   m;
        logic [7:0] ea;
        logic [7:0] eb;
        logic       a_inf;
        logic       b_inf;
        logic       a_zero;
        logic       b_zero;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        m.sign = a[31] ^ b[31];
        m.prod = {24'd0, |a[30:23], a[22:0]} * {24'd0, |b[30:23], b[22:0]};
        m.esum = {1'b0, ea} + {1'b0, eb};
        priority if (is_nan(a) || is_nan(b))
        begin
            m.kind = K_ZERO;
            m.sign = 1'b0;
        end
        else if ((a_inf && b_zero) || (b_inf && a_zero))
            m.kind = K_NAN;
        else if (a_inf || b_inf)
            m.kind = K_INF;
        else if (a_zero || b_zero)
            m.kind = K_ZERO;
        else
            m.kind = K_NUM;
        return m;
    endfunction

    function automatic fp_res_t mul_back(mul_mid_t m);
        fp_res_t            r;
        logic [5:0]         lead;
        logic [47:0]        sh;
        logic signed [10:0] exp;
        lead = 6'd0;
        for (int i = 0; i < 48; i++)
            if (m.prod[i])
                lead = 6'(i);
        sh = m.prod << (6'd47 - lead);
        exp = $signed({5'd0, lead}) + $signed({2'd0, m.esum}) - 11'sd173;
        r.nan = 1'b0;
        unique case (m.kind)
            K_NAN:
            begin
                r.nan = 1'b1;
                r.bits = QnanBits;
            end
            K_INF:  r.bits = {m.sign, 8'hFF, 23'd0};
            K_ZERO: r.bits = {m.sign, 31'd0};
            default: r.bits = round_pack(m.sign, exp, {sh[47:24], sh[23], |sh[22:0]});
        endcase
        return r;
    endfunction

    function automatic add_mid_t add_front(logic [31:0] a, logic [31:0] b);
        add_mid_t    m;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [26:0] aa;
        logic [26:0] bf;
        logic [26:0] bb;
        logic        x_inf;
        logic        y_inf;
        if (a[30:0] < b[30:0])
        begin
            x = b;
            y = a;
        end
        else
        begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d = ex - ey;
        aa = {|x[30:23], x[22:0], 3'd0};
        bf = {|y[30:23], y[22:0], 3'd0};
        if (d > 8'd26)
        begin
            bb = {26'd0, |bf};
        end
        else
        begin
            bb = bf >> d[4:0];
            bb[0] = bb[0] | (|(bf & ~({27{1'b1}} << d[4:0])));
        end
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        m.sign = x[31];
        m.zero_sign = a[31] & b[31];
        m.exp = ex;
        m.sum = (x[31] == y[31]) ? ({1'b0, aa} + {1'b0, bb}) : ({1'b0, aa} - {1'b0, bb});
        priority if (is_nan(a) || is_nan(b))
            m.kind = K_NAN;
        else if (x_inf && y_inf && (x[31] != y[31]))
            m.kind = K_NAN;
        else if (x_inf)
            m.kind = K_INF;
        else
            m.kind = K_NUM;
        return m;
    endfunction

    function automatic fp_res_t add_back(add_mid_t m);
        fp_res_t            r;
        logic [4:0]         lead;
        logic [27:0]        sh;
        logic signed [10:0] exp;
        lead = 5'd0;
        for (int i = 0; i < 28; i++)
            if (m.sum[i])
                lead = 5'(i);
        sh = m.sum << (5'd27 - lead);
        exp = $signed({3'd0, m.exp}) + $signed({6'd0, lead}) - 11'sd26;
        r.nan = 1'b0;
        priority if (m.kind == K_NAN)
        begin
            r.nan = 1'b1;
            r.bits = QnanBits;
        end
        else if (m.kind == K_INF)
            r.bits = {m.sign, 8'hFF, 23'd0};
        else if (m.sum == 28'd0)
            r.bits = {m.zero_sign, 31'd0};
        else
            r.bits = round_pack(m.sign, exp, {sh[27:4], sh[3], |sh[2:0]});
        return r;
    endfunction

endpackage

### design/nsm3_lane.sv
// nsm3_lane: one dot-product lane, three guarded products then two adds
// on one shared multiply unit and one add unit; uses nsm3_pkg
module nsm3_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  nsm3_pkg::lane_ops_t ops,
    output nsm3_pkg::lane_stat_t stat
);
    import nsm3_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL_A,
        L_MUL_B,
        L_ADD_A,
        L_ADD_B
    } lane_state_t;

    lane_state_t      state_reg;
    logic [1:0]       k_reg;
    logic             second_reg;
    logic             nan_reg;
    logic             done_reg;
    lane_ops_t        ops_reg;
    logic [2:0][31:0] prod_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      result_reg;
    mul_mid_t         mmid_reg;
    add_mid_t         amid_reg;
    fp_res_t          mres;
    fp_res_t          ares;

    always_comb
    begin
        mres = mul_back(mmid_reg);
        ares = add_back(amid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= L_IDLE;
            k_reg      <= 2'd0;
            second_reg <= 1'b0;
            nan_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        ops_reg    <= ops;
                        k_reg      <= 2'd0;
                        nan_reg    <= 1'b0;
                        second_reg <= 1'b0;
                        state_reg  <= L_MUL_A;
                    end
                end
                L_MUL_A:
                begin
                    mmid_reg  <= mul_front(ops_reg.left[k_reg], ops_reg.right[k_reg]);
                    state_reg <= L_MUL_B;
                end
                L_MUL_B:
                begin
                    prod_reg[k_reg] <= mres.bits;
                    nan_reg <= nan_reg | mres.nan;
                    if (k_reg == 2'd2)
                        state_reg <= L_ADD_A;
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= L_MUL_A;
                    end
                end
                L_ADD_A:
                begin
                    if (second_reg)
                        amid_reg <= add_front(acc_reg, prod_reg[2]);
                    else
                        amid_reg <= add_front(prod_reg[0], prod_reg[1]);
                    state_reg <= L_ADD_B;
                end
                L_ADD_B:
                begin
                    if (second_reg)
                    begin
                        result_reg <= nan_reg ? 32'd0 : ares.bits;
                        done_reg   <= 1'b1;
                        state_reg  <= L_IDLE;
                    end
                    else
                    begin
                        acc_reg    <= ares.bits;
                        second_reg <= 1'b1;
                        state_reg  <= L_ADD_A;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = result_reg;

endmodule

### design/nan_safe_matrix3_multiply.sv
// nan_safe_matrix3_multiply: top level, row stores, nine lanes and the
// merging result register; uses nsm3_pkg and nsm3_lane
//
// usage:
//   row channel (row_valid/row_ready/row_item) takes one item per matrix row,
//   carrying one row of lhs and the same row of rhs with its row index.
//   rows 0 and 1 are stored and give no result; a row index of three is
//   taken and dropped. row 2 starts the product.
//   result channel (result_valid/result_ready/result_item) carries all nine
//   entries of lhs times rhs, row-major.
//   the result is computed by each lane's single multiply unit (three products
//   in turn) and its single add unit (two sums in turn), then captured in the
//   merging register; nine lanes run together. rows 0 and 1 are taken at one
//   item a cycle while row_ready is high.
//   row_ready is low from the row 2 item until the cycle after its result
//   is taken; a stalled receiver holds the result and blocks further items.
//   reset clears the handshake state; stored rows are undefined until
//   written.
module nan_safe_matrix3_multiply (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                row_valid,
    output logic                row_ready,
    input  nsm3_pkg::nsm3_in_t  row_item,
    output logic                result_valid,
    input  logic                result_ready,
    output nsm3_pkg::nsm3_out_t result_item
);
    import nsm3_pkg::*;

    logic [31:0]      left_store_reg  [RowsKept*Dim];
    logic [31:0]      right_store_reg [RowsKept*Dim];
    logic             busy_reg;
    logic             result_valid_reg;
    nsm3_out_t        result_reg;
    logic             row_take;
    logic             start;
    logic [2:0]       row_base;
    logic [2:0][2:0][31:0] lm;
    logic [2:0][2:0][31:0] rm;
    lane_ops_t        ops   [Lanes];
    lane_stat_t       stat  [Lanes];
    logic [Lanes-1:0] done_vec;

    assign row_ready = !busy_reg;
    assign row_take  = row_valid && row_ready;
    assign start     = row_take && (row_item.row_index == LastRow);
    assign row_base  = 3'(row_item.row_index) * 3'(Dim);

    always_comb
    begin
        for (int j = 0; j < Dim; j++)
        begin
            lm[0][j] = left_store_reg[j];
            lm[1][j] = left_store_reg[Dim + j];
            rm[0][j] = right_store_reg[j];
            rm[1][j] = right_store_reg[Dim + j];
        end
        lm[2][0] = row_item.left_col0;
        lm[2][1] = row_item.left_col1;
        lm[2][2] = row_item.left_col2;
        rm[2][0] = row_item.right_col0;
        rm[2][1] = row_item.right_col1;
        rm[2][2] = row_item.right_col2;
        for (int i = 0; i < Dim; i++)
            for (int j = 0; j < Dim; j++)
                for (int k = 0; k < Dim; k++)
                begin
                    ops[i*Dim + j].left[k]  = lm[i][k];
                    ops[i*Dim + j].right[k] = rm[k][j];
                end
    end

    for (genvar i = 0; i < Dim; i++)
    begin : g_row
        for (genvar j = 0; j < Dim; j++)
        begin : g_col
            nsm3_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .start (start),
                .ops   (ops[i*Dim + j]),
                .stat  (stat[i*Dim + j])
            );
            assign done_vec[i*Dim + j] = stat[i*Dim + j].done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_take && (row_item.row_index < LastRow))
        begin
            left_store_reg[row_base]          <= row_item.left_col0;
            left_store_reg[row_base + 3'd1]   <= row_item.left_col1;
            left_store_reg[row_base + 3'd2]   <= row_item.left_col2;
            right_store_reg[row_base]         <= row_item.right_col0;
            right_store_reg[row_base + 3'd1]  <= row_item.right_col1;
            right_store_reg[row_base + 3'd2]  <= row_item.right_col2;
        end
        if (&done_vec)
        begin
            result_reg.out_r0c0 <= stat[0].value;
            result_reg.out_r0c1 <= stat[1].value;
            result_reg.out_r0c2 <= stat[2].value;
            result_reg.out_r1c0 <= stat[3].value;
            result_reg.out_r1c1 <= stat[4].value;
            result_reg.out_r1c2 <= stat[5].value;
            result_reg.out_r2c0 <= stat[6].value;
            result_reg.out_r2c1 <= stat[7].value;
            result_reg.out_r2c2 <= stat[8].value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                busy_reg <= 1'b0;
            if (&done_vec)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !row_ready)
        else $error("row item taken while result pending");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("busy not set after last row");

    a_done_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_vec[0] |-> (busy_reg && !result_valid_reg && (&done_vec)))
        else $error("lane finished outside a product");

endmodule
